@@ rtl/mtf_pkg.sv @@
// Shared types and constants for the move-to-front list unit.
package mtf_pkg;

   // Fixed widths of the request and response fields
   localparam int unsigned KEY_W = 8;
   localparam int unsigned POS_W = 4;
   localparam int unsigned CNT_W = 5;

   // Request action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY
   } mtf_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic latch_req;    // capture the incoming request
      logic latch_match;  // register the compare vector of all cells
      logic apply;        // reorder / append and load the response register
   } mtf_cmd_type;

endpackage

@@ rtl/mtf_ctrl.sv @@
// Controller: sequences search and update of each request and owns the handshakes.
module mtf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mtf_pkg::mtf_cmd_type cmd
);
   import mtf_pkg::*;

   mtf_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // The response register can take a new result if empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      req_stall       = 1'b1;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.latch_match = 1'b1;
            state_in        = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               req_stall    = 1'b0;
               if (req_valid) begin
                  cmd.latch_req = 1'b1;
                  state_in      = ST_SEARCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_apply_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_valid_ff)
      else $error("response register not loaded after update");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.apply)
      else $error("waiting response overwritten");

   a_search_then_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |=> (state_ff == ST_APPLY))
      else $error("search not followed by update");

   a_accept_state: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == ST_IDLE || state_ff == ST_APPLY))
      else $error("request accepted mid-operation");

endmodule

@@ rtl/mtf_datapath.sv @@
// Datapath: row of compare-and-shift key cells, fill count and response register.
module mtf_datapath #(
   parameter int unsigned DEPTH    = 16,
   parameter int unsigned KEY_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mtf_pkg::mtf_cmd_type         cmd,
   input  logic                         req_action,
   input  logic [mtf_pkg::KEY_W-1:0]    req_key,
   input  logic [mtf_pkg::POS_W-1:0]    req_read_pos,
   output logic                         rsp_was_present,
   output logic [mtf_pkg::POS_W-1:0]    rsp_old_pos,
   output logic                         rsp_dropped,
   output logic [mtf_pkg::CNT_W-1:0]    rsp_entry_count,
   output logic [mtf_pkg::KEY_W-1:0]    rsp_read_key,
   output logic                         rsp_read_valid
);
   import mtf_pkg::*;

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   // Latched request
   logic                action_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [POS_W-1:0]    pos_ff;

   logic [KEY_BITS-1:0] cells_ff [DEPTH];
   logic [DEPTH-1:0]    match_ff, match_in;
   logic [DEPTH-1:0]    take_prev;   // cell takes its front neighbour's key
   logic [CW-1:0]       fill_ff, fill_in;

   logic [KEY_BITS+KEY_W-1:0] key_ext;
   logic                      found, full, do_move, do_append;
   logic [PW-1:0]             found_pos;
   logic [PW+POS_W-1:0]       found_pos_ext;
   logic [CW+POS_W-1:0]       fill_pos_ext;
   logic [CW+POS_W-1:0]       rpos_ext, fill_cmp_ext;
   logic                      rd_hit;
   logic [KEY_BITS-1:0]       rd_cell;
   logic [KEY_BITS+KEY_W-1:0] rd_key_ext;
   logic [CW+CNT_W-1:0]       cnt_ext;

   logic             was_present_ff, was_present_in;
   logic [POS_W-1:0] old_pos_ff, old_pos_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [KEY_W-1:0] read_key_ff, read_key_in;
   logic             read_valid_ff, read_valid_in;

   // Keys are held at KEY_BITS; wider settings zero-fill
   assign key_ext = {{KEY_BITS{1'b0}}, req_key};

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         action_ff <= req_action;
         key_ff    <= key_ext[KEY_BITS-1:0];
         pos_ff    <= req_read_pos;
      end
      if (cmd.latch_match) begin
         match_ff <= match_in;
      end
   end

   // Compare every live cell against the request key at once
   for (genvar j = 0; j < DEPTH; j++) begin : g_cmp
      assign match_in[j] = (cells_ff[j] == key_ff) && (CW'(j) < fill_ff);
      if (j == 0) begin : g_front
         assign take_prev[j] = 1'b0;
      end else begin : g_rest
         assign take_prev[j] = |match_ff[DEPTH-1:j];
      end
   end

   // Keys are distinct, so at most one match: OR the positions together
   always_comb begin
      found_pos = '0;
      for (int unsigned j = 0; j < DEPTH; j++) begin
         if (match_ff[j]) begin
            found_pos = found_pos | PW'(j);
         end
      end
   end

   assign found     = |match_ff;
   assign full      = (fill_ff == CW'(DEPTH));
   assign do_move   = cmd.apply && (action_ff == ACT_INSERT) && found;
   assign do_append = cmd.apply && (action_ff == ACT_INSERT) && !found && !full;

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      if (j == 0) begin : g_front
         always_ff @(posedge clock) begin
            if (do_move || (do_append && fill_ff == CW'(j))) begin
               cells_ff[j] <= key_ff;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (do_move && take_prev[j]) begin
               cells_ff[j] <= cells_ff[j-1];
            end else if (do_append && fill_ff == CW'(j)) begin
               cells_ff[j] <= key_ff;
            end
         end
      end
   end

   assign fill_in = do_append ? fill_ff + CW'(1) : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Position and count fields keep their low bits for deep lists
   assign found_pos_ext = {{POS_W{1'b0}}, found_pos};
   assign fill_pos_ext  = {{POS_W{1'b0}}, fill_ff};
   assign rpos_ext      = {{CW{1'b0}}, pos_ff};
   assign fill_cmp_ext  = {{POS_W{1'b0}}, fill_ff};
   assign rd_hit        = rpos_ext < fill_cmp_ext;
   assign rd_cell       = cells_ff[rpos_ext[PW-1:0]];
   assign rd_key_ext    = {{KEY_W{1'b0}}, rd_cell};
   assign cnt_ext       = {{CNT_W{1'b0}}, fill_in};

   always_comb begin
      was_present_in = 1'b0;
      old_pos_in     = '0;
      dropped_in     = 1'b0;
      read_key_in    = '0;
      read_valid_in  = 1'b0;
      entry_count_in = cnt_ext[CNT_W-1:0];
      if (action_ff == ACT_READ) begin
         if (rd_hit) begin
            read_valid_in = 1'b1;
            read_key_in   = rd_key_ext[KEY_W-1:0];
         end
      end else if (found) begin
         was_present_in = 1'b1;
         old_pos_in     = found_pos_ext[POS_W-1:0];
      end else if (!full) begin
         old_pos_in = fill_pos_ext[POS_W-1:0];
      end else begin
         dropped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         was_present_ff <= was_present_in;
         old_pos_ff     <= old_pos_in;
         dropped_ff     <= dropped_in;
         entry_count_ff <= entry_count_in;
         read_key_ff    <= read_key_in;
         read_valid_ff  <= read_valid_in;
      end
   end

   assign rsp_was_present = was_present_ff;
   assign rsp_old_pos     = old_pos_ff;
   assign rsp_dropped     = dropped_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_read_key    = read_key_ff;
   assign rsp_read_valid  = read_valid_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count beyond list depth");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> $onehot0(match_ff))
      else $error("key held in more than one cell");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      do_append |=> (fill_ff == $past(fill_ff) + CW'(1)))
      else $error("append did not grow the list");

endmodule

@@ rtl/move_to_front_list_unit.sv @@
// Top level of the move-to-front list unit: controller plus cell datapath.
// A request passes through a search step and an update step. The search compares
// the key against every cell of the list in parallel; the update shifts the cells
// ahead of a hit back by one place (or appends at the back) and loads the
// response register. The next request is taken in the update step of the one
// before it; a stalled response holds the unit in its update step until the
// response is taken. Inserts of a new key into a full list are refused and
// flagged as dropped.
module move_to_front_list_unit #(
   parameter int unsigned DEPTH    = 16,
   parameter int unsigned KEY_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [mtf_pkg::KEY_W-1:0]    req_key,
   input  logic [mtf_pkg::POS_W-1:0]    req_read_pos,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_was_present,
   output logic [mtf_pkg::POS_W-1:0]    rsp_old_pos,
   output logic                         rsp_dropped,
   output logic [mtf_pkg::CNT_W-1:0]    rsp_entry_count,
   output logic [mtf_pkg::KEY_W-1:0]    rsp_read_key,
   output logic                         rsp_read_valid
);
   import mtf_pkg::*;

   mtf_cmd_type cmd;

   mtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mtf_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_read_pos    (req_read_pos),
      .rsp_was_present (rsp_was_present),
      .rsp_old_pos     (rsp_old_pos),
      .rsp_dropped     (rsp_dropped),
      .rsp_entry_count (rsp_entry_count),
      .rsp_read_key    (rsp_read_key),
      .rsp_read_valid  (rsp_read_valid)
   );

endmodule

@@ tb/mtf_list_checker.sv @@
// Checker for the move-to-front list unit: tracks the list, predicts each response and compares.
module mtf_list_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_action,
   input  logic [mtf_pkg::KEY_W-1:0]   req_key,
   input  logic [mtf_pkg::POS_W-1:0]   req_read_pos,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_was_present,
   input  logic [mtf_pkg::POS_W-1:0]   rsp_old_pos,
   input  logic                        rsp_dropped,
   input  logic [mtf_pkg::CNT_W-1:0]   rsp_entry_count,
   input  logic [mtf_pkg::KEY_W-1:0]   rsp_read_key,
   input  logic                        rsp_read_valid,
   output int unsigned                 fail_count,
   output int unsigned                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import mtf_pkg::*;

   localparam int LIST_DEPTH = 16;

   typedef struct packed {
      logic             was_present;
      logic [POS_W-1:0] old_pos;
      logic             dropped;
      logic [CNT_W-1:0] entry_count;
      logic [KEY_W-1:0] read_key;
      logic             read_valid;
   } mtf_result_type;

   logic [KEY_W-1:0] list_keys [LIST_DEPTH];
   int               list_fill;
   mtf_result_type   due_responses [$];

   initial begin
      fail_count = 0;
      pending_count = 0;
      list_fill = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // Applies one request to the tracked list and returns the response it should give.
   function automatic mtf_result_type apply_mtf(input logic act, input logic [KEY_W-1:0] key,
                                                input logic [POS_W-1:0] pos);
      mtf_result_type res;
      int hit;
      res = '0;
      hit = -1;
      if (act == ACT_INSERT) begin
         for (int i = 0; i < list_fill; i++) begin
            if (hit < 0 && list_keys[i] == key) hit = i;
         end
         if (hit >= 0) begin
            // entries ahead of the hit slide back one place
            for (int j = hit; j > 0; j--) list_keys[j] = list_keys[j-1];
            list_keys[0] = key;
            res.was_present = 1'b1;
            res.old_pos = POS_W'(hit);
         end else if (list_fill < LIST_DEPTH) begin
            list_keys[list_fill] = key;
            res.old_pos = POS_W'(list_fill);
            list_fill++;
         end else begin
            res.dropped = 1'b1;
         end
      end else if (int'(pos) < list_fill) begin
         res.read_valid = 1'b1;
         res.read_key = list_keys[pos];
      end
      res.entry_count = CNT_W'(list_fill);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      mtf_result_type want;
      if (reset) begin
         due_responses.delete();
         list_fill = 0;
      end else begin
         if (req_valid && !req_stall)
            due_responses.push_back(apply_mtf(req_action, req_key, req_read_pos));
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = due_responses.pop_front();
               if (rsp_was_present !== want.was_present)
                  report_mismatch($sformatf("was_present got %0h expected %0h",
                                            rsp_was_present, want.was_present));
               if (rsp_old_pos !== want.old_pos)
                  report_mismatch($sformatf("old_pos got %0h expected %0h",
                                            rsp_old_pos, want.old_pos));
               if (rsp_dropped !== want.dropped)
                  report_mismatch($sformatf("dropped got %0h expected %0h",
                                            rsp_dropped, want.dropped));
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count got %0h expected %0h",
                                            rsp_entry_count, want.entry_count));
               if (rsp_read_key !== want.read_key)
                  report_mismatch($sformatf("read_key got %0h expected %0h",
                                            rsp_read_key, want.read_key));
               if (rsp_read_valid !== want.read_valid)
                  report_mismatch($sformatf("read_valid got %0h expected %0h",
                                            rsp_read_valid, want.read_valid));
            end
         end
      end
      pending_count <= due_responses.size();
   end

endmodule

@@ tb/move_to_front_list_unit_test.sv @@
// Testbench top for the move-to-front list unit: clock, reset, request stimulus and verdict.
module move_to_front_list_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mtf_pkg::*;

   localparam int unsigned RANDOM_REQUESTS = 525;
   localparam int unsigned LONG_HOLD       = 200;
   localparam int unsigned CYCLE_LIMIT     = 200000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic             req_action;
   logic [KEY_W-1:0] req_key;
   logic [POS_W-1:0] req_read_pos;
   logic             rsp_valid;
   logic             rsp_stall;
   logic             rsp_was_present;
   logic [POS_W-1:0] rsp_old_pos;
   logic             rsp_dropped;
   logic [CNT_W-1:0] rsp_entry_count;
   logic [KEY_W-1:0] rsp_read_key;
   logic             rsp_read_valid;
   int unsigned      fail_count;
   int unsigned      pending_count;
   int unsigned      cycle_count;

   // keys known to sit in the list once it has filled up
   logic [KEY_W-1:0] resident_keys [16];

   move_to_front_list_unit DUT (.*);

   mtf_list_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[move_to_front_list_unit] ERROR");
         $finish;
      end
   end

   // mostly short idles, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 30);
   endfunction

   task automatic send_request(input logic act, input logic [KEY_W-1:0] key,
                               input logic [POS_W-1:0] pos, input int unsigned gap);
      req_valid <= 1'b1;
      req_action <= act;
      req_key <= key;
      req_read_pos <= pos;
      do @(posedge clock); while (req_stall);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side pacing, with one long hold-off so the unit backs up
   initial begin : rsp_pacing
      int unsigned step;
      int unsigned hold;
      rsp_stall <= 1'b0;
      step = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (step == 40) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (step % 50 == 25) begin
            rsp_stall <= 1'b0;
            repeat (80) @(posedge clock);
         end else begin
            hold = pick_gap();
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
         step++;
      end
   end

   initial begin : stimulus
      int unsigned r;
      int unsigned gap;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_INSERT;
      req_key <= '0;
      req_read_pos <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty list, first appends, hits at the front and one behind it
      send_request(ACT_READ, 8'hA5, 4'd15, pick_gap());
      send_request(ACT_INSERT, 8'h00, 4'd9, pick_gap());
      send_request(ACT_INSERT, 8'hFF, 4'd0, pick_gap());
      send_request(ACT_INSERT, 8'h00, 4'd15, pick_gap());
      send_request(ACT_INSERT, 8'hFF, 4'd0, pick_gap());
      send_request(ACT_READ, 8'hFF, 4'd0, pick_gap());
      send_request(ACT_READ, 8'h00, 4'd1, pick_gap());
      send_request(ACT_READ, 8'h3C, 4'd2, pick_gap());
      resident_keys[0] = 8'hFF;
      resident_keys[1] = 8'h00;
      // fill to capacity
      for (int k = 1; k <= 14; k++) begin
         resident_keys[k+1] = KEY_W'(k * 17);
         send_request(ACT_INSERT, KEY_W'(k * 17), POS_W'(k), pick_gap());
      end
      // full list: a new key is refused, the back entry jumps to the front
      send_request(ACT_INSERT, 8'h5A, 4'd3, pick_gap());
      send_request(ACT_INSERT, resident_keys[15], 4'd0, pick_gap());
      send_request(ACT_READ, 8'h00, 4'd15, pick_gap());

      for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
         gap = ((i / 60) % 3 == 1) ? 0 : pick_gap();
         r = $urandom_range(0, 99);
         if (r < 45)
            send_request(ACT_INSERT, resident_keys[$urandom_range(0, 15)],
                         POS_W'($urandom_range(0, 15)), gap);
         else if (r < 65)
            send_request(ACT_INSERT, KEY_W'($urandom_range(0, 255)),
                         POS_W'($urandom_range(0, 15)), gap);
         else
            send_request(ACT_READ, KEY_W'($urandom_range(0, 255)),
                         POS_W'($urandom_range(0, 15)), gap);
         if (i == 250) begin
            // let the unit drain completely before carrying on
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("[move_to_front_list_unit] OK");
      else
         $display("[move_to_front_list_unit] ERROR");
      $finish;
   end

endmodule
